// ===== rtl/snaw_pkg.sv =====
// snaw_pkg: shared types and constants of the strided N-dimensional address walker.
// No dependencies; imported by every module of the block.
package snaw_pkg;

	localparam int AXES    = 4;
	localparam int COORD_W = 16;
	localparam int TGT_W   = 17;
	localparam int IDX_W   = 32;
	localparam int OUT_AW  = 32;
	localparam int CFG_W   = 64;
	localparam int CFG_IW  = 3;

	localparam logic [1:0] OP_ORIGIN = 2'd0;
	localparam logic [1:0] OP_NEXT   = 2'd1;
	localparam logic [1:0] OP_GOTO   = 2'd2;

	localparam logic [CFG_IW-1:0] REG_BASE    = 3'd0;
	localparam logic [CFG_IW-1:0] REG_ESIZE   = 3'd1;
	localparam logic [CFG_IW-1:0] REG_DIMS    = 3'd2;
	localparam logic [CFG_IW-1:0] REG_CONTIG  = 3'd3;
	localparam logic [CFG_IW-1:0] REG_EXTENTS = 3'd4;
	localparam logic [CFG_IW-1:0] REG_STRIDES = 3'd5;

	// cycles the derived stride tables need after a register write
	localparam logic [1:0] SETTLE_CYCLES = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_GOTO
	} state_t;

	typedef struct packed {
		logic origin;
		logic step;
		logic goto_start;
		logic goto_step;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic iter_last;
	} dp_status_t;

	// addr in the lowest bits, then idx, then pos[0] .. pos[3]
	typedef struct packed {
		logic [AXES-1:0][COORD_W-1:0] pos;
		logic [IDX_W-1:0]             idx;
		logic [OUT_AW-1:0]            addr;
	} result_t;

endpackage

// ===== rtl/strided_nd_address_walker.sv =====
// Strided N-dimensional address walker, top level.
// Instantiates snaw_ctrl, snaw_dp and snaw_outq; depends on snaw_pkg.
//
// Each transfer on the slave side is one operation (tuser): reset to origin, step to the
// next element, or jump to signed per-axis coordinates; each produces one result transfer
// with byte address, flat index and the four coordinates. Reset, next and unused codes run
// back to back, one per clock while the result queue has space and no register write is
// settling; the odometer step is a single add of a precomputed per-axis delta. Goto runs
// one multiply-accumulate per axis, last axis first, and takes no new input until done.
// Results sit in a two-entry queue, so input keeps flowing while one result waits. After
// any register write the input stalls while the backstride and delta tables are rebuilt.
module strided_nd_address_walker import snaw_pkg::*; #(
	parameter int MAX_AXES     = 4,
	parameter int ADDRESS_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [71:0]       s_tdata,   // target_0, target_1, target_2, target_3, pad
	input  logic [1:0]        s_tuser,   // operation
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [127:0]      m_tdata,   // byte_address, element_index, position_0..3
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	cmd_t       cmd;
	dp_status_t status;
	result_t    result_d;
	result_t    q_data;
	logic       q_space;

	snaw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.op       (s_tuser),
		.q_space  (q_space),
		.cfg_we   (cfg_we),
		.status   (status),
		.cmd      (cmd)
	);

	snaw_dp #(
		.MAX_AXES     (MAX_AXES),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.targets   (s_tdata[AXES*TGT_W-1:0]),
		.status    (status),
		.result_d  (result_d)
	);

	snaw_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd.push),
		.din      (result_d),
		.space    (q_space),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (q_data)
	);

	assign m_tdata = q_data;

	a_push_space: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> q_space)
		else $error("result pushed into a full queue");

	a_goto_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.goto_step |-> !s_tready)
		else $error("input ready during goto sequence");

	a_cfg_holdoff: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !s_tready)
		else $error("input ready before stride tables settled");

endmodule

// ===== rtl/snaw_ctrl.sv =====
// snaw_ctrl: operation sequencer of the address walker.
// Decodes accepted operations into datapath commands, runs the goto sequence.
// Depends on snaw_pkg.
module snaw_ctrl import snaw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [1:0] op,
	input  logic       q_space,
	input  logic       cfg_we,
	input  dp_status_t status,
	output cmd_t       cmd
);

	state_t     state_q, state_d;
	logic [1:0] settle_q;
	logic       accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			settle_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				settle_q <= SETTLE_CYCLES;
			end else if (settle_q != '0) begin
				settle_q <= settle_q - 2'd1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && op == OP_GOTO) state_d = ST_GOTO;
			end
			ST_GOTO: begin
				if (status.iter_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready       = (state_q == ST_IDLE) && q_space && (settle_q == '0);
		accept         = s_tvalid && s_tready;
		cmd.origin     = accept && (op == OP_ORIGIN);
		cmd.step       = accept && (op == OP_NEXT);
		cmd.goto_start = accept && (op == OP_GOTO);
		cmd.goto_step  = (state_q == ST_GOTO);
		// unused codes report the held state at once
		cmd.push       = (accept && op != OP_GOTO) ||
		                 (state_q == ST_GOTO && status.iter_last);
	end

endmodule

// ===== rtl/snaw_dp.sv =====
// snaw_dp: datapath of the address walker: registers, derived stride tables,
// odometer step and the per-axis multiply-accumulate used by goto.
// Depends on snaw_pkg.
module snaw_dp import snaw_pkg::*; #(
	parameter int MAX_AXES     = 4,
	parameter int ADDRESS_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IW-1:0]       cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  cmd_t                    cmd,
	input  logic [AXES*TGT_W-1:0]   targets,
	output dp_status_t              status,
	output result_t                 result_d
);

	localparam int NA = (MAX_AXES < AXES) ? MAX_AXES : AXES;
	localparam int AW = ADDRESS_BITS;
	localparam int KW = (NA > 1) ? $clog2(NA) : 1;

	// configuration
	logic [31:0]      base_q;
	logic [7:0]       esize_q;
	logic [2:0]       dims_q;
	logic             contig_q;
	logic [CFG_W-1:0] ext_q;
	logic [CFG_W-1:0] stride_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			esize_q  <= 8'd1;
			dims_q   <= 3'd1;
			contig_q <= 1'b0;
			ext_q    <= '0;
			stride_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE:    base_q   <= cfg_data[31:0];
				REG_ESIZE:   esize_q  <= cfg_data[7:0];
				REG_DIMS:    dims_q   <= cfg_data[2:0];
				REG_CONTIG:  contig_q <= cfg_data[0];
				REG_EXTENTS: ext_q    <= cfg_data;
				REG_STRIDES: stride_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [COORD_W-1:0]        em1  [NA];
	logic signed [COORD_W-1:0] strd [NA];
	logic [2:0]                n_act;

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			em1[i]  = ext_q[COORD_W*i +: COORD_W];
			strd[i] = $signed(stride_q[COORD_W*i +: COORD_W]);
		end
	end

	always_comb begin
		if (dims_q == 3'd0)         n_act = 3'd1;
		else if (dims_q > 3'(NA))   n_act = 3'(NA);
		else                        n_act = dims_q;
	end

	// backstrides, then per-axis step deltas for a carry that stops at axis i
	logic signed [32:0] bs_prod [NA];
	logic [AW-1:0]      bs_q    [NA];
	logic [AW-1:0]      sfx     [NA+1];
	logic [AW-1:0]      delta_q [NA];
	logic [AW-1:0]      wrap_q;

	always_comb begin
		for (int i = 0; i < NA; i++) bs_prod[i] = strd[i] * $signed({1'b0, em1[i]});
		sfx[NA] = '0;
		for (int j = NA - 1; j >= 0; j--) begin
			sfx[j] = sfx[j+1] + ((3'(j) < n_act) ? bs_q[j] : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NA; i++) begin
				bs_q[i]    <= '0;
				delta_q[i] <= '0;
			end
			wrap_q <= '0;
		end else begin
			for (int i = 0; i < NA; i++) begin
				bs_q[i]    <= AW'(bs_prod[i]);
				delta_q[i] <= AW'(strd[i]) - sfx[i+1];
			end
			wrap_q <= '0 - sfx[0];
		end
	end

	// walker state
	logic [AW-1:0]      cur_addr_q;
	logic [IDX_W-1:0]   cur_idx_q;
	logic [COORD_W-1:0] pos_q [NA];

	// odometer step; with one or two axes, axis 0 never wraps
	logic               found;
	logic [KW-1:0]      stop_ax;
	logic               dense;
	logic [AW-1:0]      step_addr;
	logic [COORD_W-1:0] step_pos [NA];

	always_comb begin
		found   = 1'b0;
		stop_ax = '0;
		for (int i = 0; i < NA; i++) begin
			if ((3'(i) < n_act) &&
			    ((pos_q[i] < em1[i]) || (i == 0 && n_act <= 3'd2))) begin
				found   = 1'b1;
				stop_ax = KW'(i);
			end
		end
	end

	always_comb begin
		dense = contig_q && (n_act != 3'd1);
		if (dense)      step_addr = cur_addr_q + AW'(esize_q);
		else if (found) step_addr = cur_addr_q + delta_q[stop_ax];
		else            step_addr = cur_addr_q + wrap_q;
		for (int i = 0; i < NA; i++) begin
			step_pos[i] = pos_q[i];
			if (!dense && (3'(i) < n_act)) begin
				if (found && KW'(i) == stop_ax)        step_pos[i] = pos_q[i] + 16'd1;
				else if (!found || KW'(i) > stop_ax)   step_pos[i] = '0;
			end
		end
	end

	// goto: one axis per cycle, last axis first
	logic [TGT_W-1:0]   tgt_q [NA];
	logic [KW-1:0]      k_q;
	logic [AW-1:0]      acc_addr_q;
	logic [IDX_W-1:0]   acc_idx_q;
	logic [IDX_W-1:0]   factor_q;

	logic [COORD_W-1:0] g_em1;
	logic [TGT_W-1:0]   g_tgt;
	logic [COORD_W-1:0] g_coord;
	logic signed [32:0] g_aprod;
	logic [47:0]        g_iprod;
	logic [48:0]        g_fprod;
	logic [AW-1:0]      g_addr;
	logic [IDX_W-1:0]   g_idx;

	always_comb begin
		g_em1   = em1[k_q];
		g_tgt   = tgt_q[k_q];
		g_coord = g_tgt[COORD_W-1:0] + (g_tgt[TGT_W-1] ? g_em1 + 16'd1 : 16'd0);
		g_aprod = $signed({1'b0, g_coord}) * strd[k_q];
		g_iprod = g_coord * factor_q;
		g_fprod = factor_q * ({1'b0, g_em1} + 17'd1);
		g_addr  = acc_addr_q + AW'(g_aprod);
		g_idx   = acc_idx_q + g_iprod[IDX_W-1:0];
	end

	assign status.iter_last = (k_q == '0);

	logic [AW-1:0]      addr_d;
	logic [IDX_W-1:0]   idx_d;
	logic [COORD_W-1:0] pos_d [NA];

	always_comb begin
		addr_d = cur_addr_q;
		idx_d  = cur_idx_q;
		for (int i = 0; i < NA; i++) pos_d[i] = pos_q[i];
		priority if (cmd.origin) begin
			addr_d = AW'(base_q);
			idx_d  = '0;
			for (int i = 0; i < NA; i++) pos_d[i] = '0;
		end else if (cmd.step) begin
			addr_d = step_addr;
			idx_d  = cur_idx_q + 32'd1;
			for (int i = 0; i < NA; i++) pos_d[i] = step_pos[i];
		end else if (cmd.goto_step) begin
			addr_d     = g_addr;
			idx_d      = g_idx;
			pos_d[k_q] = g_coord;
		end else begin
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_addr_q <= '0;
			cur_idx_q  <= '0;
			for (int i = 0; i < NA; i++) pos_q[i] <= '0;
			k_q <= '0;
		end else begin
			if (cmd.origin || cmd.step || (cmd.goto_step && status.iter_last)) begin
				cur_addr_q <= addr_d;
				cur_idx_q  <= idx_d;
			end
			if (cmd.goto_start) begin
				for (int i = 0; i < NA; i++) pos_q[i] <= '0;
				k_q <= KW'(n_act - 3'd1);
			end else if (cmd.origin || cmd.step || cmd.goto_step) begin
				for (int i = 0; i < NA; i++) pos_q[i] <= pos_d[i];
				if (cmd.goto_step) k_q <= k_q - KW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.goto_start) begin
			for (int i = 0; i < NA; i++) tgt_q[i] <= targets[TGT_W*i +: TGT_W];
			acc_addr_q <= AW'(base_q);
			acc_idx_q  <= '0;
			factor_q   <= 32'd1;
		end else if (cmd.goto_step) begin
			acc_addr_q <= g_addr;
			acc_idx_q  <= g_idx;
			factor_q   <= g_fprod[IDX_W-1:0];
		end
	end

	always_comb begin
		result_d.addr = OUT_AW'(addr_d);
		result_d.idx  = idx_d;
		for (int i = 0; i < AXES; i++) result_d.pos[i] = '0;
		for (int i = 0; i < NA; i++)   result_d.pos[i] = pos_d[i];
	end

endmodule

// ===== rtl/snaw_outq.sv =====
// snaw_outq: two-entry result queue driving the master-side stream.
// Depends on snaw_pkg.
module snaw_outq import snaw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t din,
	output logic    space,
	output logic    m_tvalid,
	input  logic    m_tready,
	output result_t m_tdata
);

	result_t    head_q, tail_q;
	logic [1:0] count_q;
	logic       pop;

	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (count_q != 2'd0);
	assign m_tdata  = head_q;
	assign space    = (count_q != 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case ({push, pop})
			2'b10: begin
				if (count_q == 2'd0) head_q <= din;
				else                 tail_q <= din;
			end
			2'b01: head_q <= tail_q;
			2'b11: begin
				if (count_q == 2'd1) begin
					head_q <= din;
				end else begin
					head_q <= tail_q;
					tail_q <= din;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== sim/snaw_walk_checker.sv =====
// Result checker for the strided N-dimensional address walker: watches the register port and
// both stream channels, keeps its own walker state and compares every result transfer.
// Depends on snaw_pkg for widths, operation and register codes and the result layout.
module snaw_walk_checker import snaw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [71:0]       s_tdata,   // target_0, target_1, target_2, target_3, pad
	input  logic [1:0]        s_tuser,   // operation
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [127:0]      m_tdata,   // byte_address, element_index, position_0..3
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	output int unsigned       outstanding,
	output int unsigned       fail_count
);

	logic [31:0] base_reg;
	logic [7:0]  esize_reg;
	logic [2:0]  dims_reg;
	logic        contig_reg;
	logic [63:0] extents_reg;
	logic [63:0] strides_reg;

	logic [31:0] walk_addr;
	logic [31:0] walk_index;
	logic [15:0] walk_pos [AXES];

	result_t     expected_walk_q [$];
	int unsigned errors;

	function automatic int active_axes();
		if (dims_reg == 3'd0)
			return 1;
		if (int'(dims_reg) > AXES)
			return AXES;
		return int'(dims_reg);
	endfunction

	function automatic logic [15:0] extent_of(input int i);
		return extents_reg[i*COORD_W +: COORD_W];
	endfunction

	function automatic logic [31:0] stride_of(input int i);
		logic [15:0] s;
		s = strides_reg[i*COORD_W +: COORD_W];
		return {{16{s[15]}}, s};
	endfunction

	task automatic clear_walk();
		int i;
		walk_addr  = base_reg;
		walk_index = '0;
		for (i = 0; i < AXES; i++)
			walk_pos[i] = '0;
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_W-1:0] val);
		case (idx)
		REG_BASE:    base_reg    = val[31:0];
		REG_ESIZE:   esize_reg   = val[7:0];
		REG_DIMS:    dims_reg    = val[2:0];
		REG_CONTIG:  contig_reg  = val[0];
		REG_EXTENTS: extents_reg = val;
		REG_STRIDES: strides_reg = val;
		default: ;
		endcase
	endtask

	task automatic step_walk(input logic [1:0] op, input logic [71:0] targets);
		int          n;
		int          i;
		bit          done;
		logic [31:0] a;
		logic [31:0] idx;
		logic [31:0] factor;
		logic [31:0] t;
		logic [16:0] tg;
		logic [15:0] c;
		n = active_axes();
		a = walk_addr;
		case (op)
		OP_ORIGIN: clear_walk();
		OP_NEXT: begin
			walk_index = walk_index + 32'd1;
			if (n == 1) begin
				a = a + stride_of(0);
				walk_pos[0] = walk_pos[0] + 16'd1;
			end else if (contig_reg) begin
				a = a + {24'd0, esize_reg};
			end else if (n == 2) begin
				if (walk_pos[1] < extent_of(1)) begin
					walk_pos[1] = walk_pos[1] + 16'd1;
					a = a + stride_of(1);
				end else begin
					// carry into axis 0, which has no bound
					walk_pos[1] = '0;
					walk_pos[0] = walk_pos[0] + 16'd1;
					a = a + stride_of(0) - stride_of(1) * {16'd0, extent_of(1)};
				end
			end else begin
				done = 0;
				for (i = n - 1; i >= 0 && !done; i--) begin
					if (walk_pos[i] < extent_of(i)) begin
						walk_pos[i] = walk_pos[i] + 16'd1;
						a = a + stride_of(i);
						done = 1;
					end else begin
						walk_pos[i] = '0;
						a = a - stride_of(i) * {16'd0, extent_of(i)};
					end
				end
			end
			walk_addr = a;
		end
		OP_GOTO: begin
			a      = base_reg;
			idx    = '0;
			factor = 32'd1;
			for (i = 0; i < AXES; i++)
				walk_pos[i] = '0;
			for (i = n - 1; i >= 0; i--) begin
				tg = targets[i*TGT_W +: TGT_W];
				t  = {15'd0, tg};
				// negative target counts back from the extent
				if (tg[TGT_W-1])
					t = t + {16'd0, extent_of(i)} + 32'd1;
				c           = t[15:0];
				walk_pos[i] = c;
				a           = a + {16'd0, c} * stride_of(i);
				idx         = idx + {16'd0, c} * factor;
				factor      = factor * ({16'd0, extent_of(i)} + 32'd1);
			end
			walk_addr  = a;
			walk_index = idx;
		end
		default: ;
		endcase
	endtask

	function automatic result_t walk_snapshot();
		result_t r;
		int      i;
		r.addr = walk_addr;
		r.idx  = walk_index;
		for (i = 0; i < AXES; i++)
			r.pos[i] = walk_pos[i];
		return r;
	endfunction

	task automatic check_walk(input result_t got);
		result_t want;
		int      i;
		if (expected_walk_q.size() == 0) begin
			$display("%0t: result transfer with none expected: %h", $time, got);
			errors++;
		end else begin
			want = expected_walk_q.pop_front();
			if (got.addr !== want.addr) begin
				$display("%0t: byte_address expected %h got %h", $time, want.addr, got.addr);
				errors++;
			end
			if (got.idx !== want.idx) begin
				$display("%0t: element_index expected %h got %h", $time, want.idx, got.idx);
				errors++;
			end
			for (i = 0; i < AXES; i++)
				if (got.pos[i] !== want.pos[i]) begin
					$display("%0t: position_%0d expected %h got %h", $time, i,
						want.pos[i], got.pos[i]);
					errors++;
				end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_reg    = '0;
			esize_reg   = 8'd1;
			dims_reg    = 3'd1;
			contig_reg  = 1'b0;
			extents_reg = '0;
			strides_reg = '0;
			clear_walk();
			expected_walk_q.delete();
			errors = 0;
			outstanding <= 0;
			fail_count  <= 0;
		end else begin
			if (cfg_we)
				write_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready) begin
				step_walk(s_tuser, s_tdata);
				expected_walk_q.push_back(walk_snapshot());
			end
			if (m_tvalid && m_tready)
				check_walk(result_t'(m_tdata));
			outstanding <= expected_walk_q.size();
			fail_count  <= errors;
		end
	end

endmodule

// ===== sim/tb_strided_nd_address_walker.sv =====
// Testbench top for strided_nd_address_walker: clock, reset, register set-up and stream
// stimulus with random gaps and stalls; snaw_walk_checker does the prediction and comparison.
// Depends on snaw_pkg, snaw_walk_checker and the RTL of the block.
module tb_strided_nd_address_walker import snaw_pkg::*;;

	localparam logic [1:0]        OP_UNUSED     = 2'd3;
	localparam logic [CFG_IW-1:0] REG_SPARE_6   = 3'd6;
	localparam logic [CFG_IW-1:0] REG_SPARE_7   = 3'd7;
	localparam int                RANDOM_PHASES = 15;
	localparam int                PHASE_ITEMS   = 130;
	localparam int unsigned       CYCLE_LIMIT   = 400000;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [71:0]       s_tdata   = '0;   // target_0, target_1, target_2, target_3, pad
	logic [1:0]        s_tuser   = '0;   // operation
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [127:0]      m_tdata;          // byte_address, element_index, position_0..3
	logic              cfg_we    = 1'b0;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data  = '0;

	int unsigned outstanding;
	int unsigned fail_count;
	int unsigned cycles = 0;
	bit          no_idle = 0;
	logic [63:0] extents_set = '0;

	strided_nd_address_walker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	snaw_walk_checker walk_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// result side: random stall before each transfer
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = no_idle ? 0 : $urandom_range(0, 3);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [TGT_W-1:0] t0, t1, t2, t3);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'd0, t3, t2, t1, t0};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic setup(input logic [63:0] base, esize, dims, contig, extents, strides);
		drain();
		put_reg(REG_BASE, base);
		put_reg(REG_ESIZE, esize);
		put_reg(REG_DIMS, dims);
		put_reg(REG_CONTIG, contig);
		put_reg(REG_EXTENTS, extents);
		put_reg(REG_STRIDES, strides);
		extents_set = extents;
	endtask

	function automatic logic [TGT_W-1:0] random_target(input logic [15:0] ext);
		int v;
		case ($urandom_range(0, 3))
		0: v = $urandom_range(0, ext);
		1: v = -int'($urandom_range(1, int'(ext) + 1));
		default: v = $urandom;
		endcase
		return v[TGT_W-1:0];
	endfunction

	task automatic random_setup();
		logic [63:0] base, esize, dims, contig, extents, strides;
		int          a;
		base    = {$urandom, $urandom};
		esize   = {$urandom, $urandom};
		dims    = {$urandom, $urandom};
		contig  = {$urandom, $urandom};
		extents = '0;
		strides = '0;
		case ($urandom_range(0, 3))
		0: base[31:0] = '0;
		1: base[31:0] = '1;
		default: ;
		endcase
		case ($urandom_range(0, 3))
		0: esize[7:0] = 8'd255;
		1: esize[7:0] = 8'd0;
		2: esize[7:0] = 8'd1;
		default: ;
		endcase
		dims[2:0] = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
			: 3'($urandom_range(1, 4));
		contig[0] = ($urandom_range(0, 3) == 0);
		for (a = 0; a < AXES; a++) begin
			case ($urandom_range(0, 7))
			0: extents[a*16 +: 16] = 16'd0;
			5: extents[a*16 +: 16] = 16'hFFFF;
			6: extents[a*16 +: 16] = 16'($urandom);
			7: extents[a*16 +: 16] = 16'($urandom_range(5, 20));
			default: extents[a*16 +: 16] = 16'($urandom_range(1, 4));
			endcase
			case ($urandom_range(0, 5))
			0: strides[a*16 +: 16] = 16'h7FFF;
			1: strides[a*16 +: 16] = 16'h8000;
			2: strides[a*16 +: 16] = 16'h0000;
			default: strides[a*16 +: 16] = 16'($urandom);
			endcase
		end
		setup(base, esize, dims, contig, extents, strides);
		if ($urandom_range(0, 3) == 0) begin
			put_reg(REG_SPARE_6, {$urandom, $urandom});
			put_reg(REG_SPARE_7, {$urandom, $urandom});
		end
	endtask

	task automatic random_item();
		int         r;
		logic [1:0] op;
		r = $urandom_range(0, 99);
		if (r < 72)
			op = OP_NEXT;
		else if (r < 84)
			op = OP_GOTO;
		else if (r < 94)
			op = OP_ORIGIN;
		else
			op = OP_UNUSED;
		send_item(op, random_target(extents_set[15:0]), random_target(extents_set[31:16]),
			random_target(extents_set[47:32]), random_target(extents_set[63:48]));
	endtask

	initial begin
		int phase;
		int k;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// one axis: stride extremes, coordinate wrap, targets counted from the end
		setup(64'hFFFF_FFF0, 64'd255, 64'd1, 64'd0, 64'h0000_0000_0000_FFFF,
			64'h0000_0000_0000_7FFF);
		send_item(OP_ORIGIN, '0, '0, '0, '0);
		send_item(OP_NEXT, '0, '0, '0, '0);
		send_item(OP_GOTO, 17'h0FFFF, '0, '0, '0);
		send_item(OP_NEXT, '0, '0, '0, '0);
		send_item(OP_GOTO, 17'h1FFFF, '0, '0, '0);
		send_item(OP_GOTO, 17'h10000, '0, '0, '0);
		send_item(OP_UNUSED, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);

		// three axes: last element then walk past the end, out-of-range targets
		setup(64'd0, 64'd1, 64'd3, 64'd0, 64'h0000_0001_0002_0001, 64'h0005_FFFF_7FFF_8000);
		send_item(OP_ORIGIN, '0, '0, '0, '0);
		send_item(OP_GOTO, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h0FFFF);
		send_item(OP_NEXT, '0, '0, '0, '0);
		send_item(OP_GOTO, 17'h0FFFF, 17'd3, 17'd5, '0);
		send_item(OP_NEXT, '0, '0, '0, '0);
		send_item(OP_NEXT, '0, '0, '0, '0);

		// two axes: carry into an unbounded outer axis
		setup(64'h1000, 64'd1, 64'd2, 64'd0, 64'h0000_0000_0002_0000, 64'h0000_0000_0004_0010);
		send_item(OP_GOTO, '0, 17'h1FFFF, '0, '0);
		send_item(OP_NEXT, '0, '0, '0, '0);
		send_item(OP_NEXT, '0, '0, '0, '0);

		// densely packed, largest extents
		setup(64'h8000_0000, 64'd255, 64'd4, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h1234_8000_7FFF_0001);
		send_item(OP_GOTO, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
		send_item(OP_NEXT, '0, '0, '0, '0);
		send_item(OP_NEXT, '0, '0, '0, '0);

		// axis count out of range on both sides
		setup(64'h40, 64'd7, 64'd0, 64'd1, 64'h0003_0003_0003_0003, 64'h0001_0002_0003_0004);
		send_item(OP_NEXT, '0, '0, '0, '0);
		setup(64'h40, 64'd7, 64'd7, 64'd0, 64'h0003_0003_0003_0003, 64'h0001_0002_0003_0004);
		send_item(OP_GOTO, 17'd1, 17'd1, 17'd1, 17'd1);
		send_item(OP_NEXT, '0, '0, '0, '0);

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			random_setup();
			no_idle = (phase % 5 == 2);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				random_item();
				if (k == PHASE_ITEMS / 2 && phase % 3 == 0)
					drain();
			end
		end

		drain();
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
